### design/swps_pkg.sv
// ----------------------------------------------------------------------------
// Smooth weighted path select: shared definitions
// Sizes, codes and the control and status words that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package swps_pkg;

   localparam int NUM_GROUPS = 16;
   localparam int MAX_PATHS  = 16;

   localparam int GROUP_W  = 4;
   localparam int PATH_W   = 16;
   localparam int WEIGHT_W = 8;
   localparam int CREDIT_W = 16;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   localparam int MEM_DEPTH = NUM_GROUPS * MAX_PATHS;
   localparam int GIDX_W    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int PIDX_W    = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
   localparam int CNT_W     = $clog2(MAX_PATHS + 1);
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int SUM_W     = $clog2(MAX_PATHS * 255 + 1);
   localparam int UPD_W     = ((SUM_W > CREDIT_W) ? SUM_W : CREDIT_W) + 2;

   localparam int REQ_FIELDS_W = GROUP_W + 1 + PATH_W + WEIGHT_W + CREDIT_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W  = ((PATH_W + 7) / 8) * 8;

   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic              accept;
      logic              rd_en;
      logic              rd_upd;
      logic [PIDX_W-1:0] rd_idx;
      logic              rsp_sel;
   } swps_cmd_type;

   typedef struct packed {
      logic             sel_start;
      logic [CNT_W-1:0] count;
   } swps_stat_type;

   function automatic logic [ADDR_W-1:0] swps_addr(input logic [GIDX_W-1:0] gidx,
                                                   input logic [PIDX_W-1:0] pidx);
      swps_addr = ADDR_W'(gidx) * ADDR_W'(MAX_PATHS) + ADDR_W'(pidx);
   endfunction

endpackage

### design/smooth_weighted_path_select_unit.sv
// ----------------------------------------------------------------------------
// Smooth weighted path select unit
// Keeps per-group path lists and picks paths by smooth weighted round robin.
// ----------------------------------------------------------------------------
// Each request word carries an action in req_tuser (load entry, delete group,
// select path) and the group, entry-first flag, path id, weight and initial
// credit in req_tdata. Every request gives exactly one response word: status
// in rsp_tuser and the chosen path id in rsp_tdata.
// Load, delete, ignored actions and selects that find no list complete in the
// accepting cycle and their response word is valid in the next cycle, so one
// such request can be taken every cycle while the receiver takes each word.
// A select on a list of n entries reads the entry memory twice, once to sum
// the weights and find the largest credit and once to write back the updated
// credits, one entry at a time through the single read port of the entry
// memory; the response word is written after the update pass. No request is
// taken while a select is at work.
// Reset empties every list at once; the entry memories keep no reset value.
// The response sits in an output register; while the receiver stalls it is
// held, and a new request is taken only in the cycle in which the pending
// word is taken or once the register is empty.
// ----------------------------------------------------------------------------
module smooth_weighted_path_select_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // group[3:0], entry_first[4], path_id[20:5], weight[28:21],
   // initial_credit[44:29], zero fill above
   input  logic [swps_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // action[1:0]
   input  logic [swps_pkg::ACTION_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // chosen_path[15:0]
   output logic [swps_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status[1:0]
   output logic [swps_pkg::STATUS_W-1:0]       rsp_tuser
);
   import swps_pkg::*;

   localparam int FIRST_LSB  = GROUP_W;
   localparam int PATH_LSB   = FIRST_LSB + 1;
   localparam int WEIGHT_LSB = PATH_LSB + PATH_W;
   localparam int CREDIT_LSB = WEIGHT_LSB + WEIGHT_W;

   swps_cmd_type        cmd;
   swps_stat_type       stat;
   logic [PATH_W-1:0]   chosen_path;

   swps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   swps_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .action         (req_tuser),
      .group          (req_tdata[GROUP_W-1:0]),
      .entry_first    (req_tdata[FIRST_LSB]),
      .path_id        (req_tdata[PATH_LSB +: PATH_W]),
      .weight         (req_tdata[WEIGHT_LSB +: WEIGHT_W]),
      .initial_credit ($signed(req_tdata[CREDIT_LSB +: CREDIT_W])),
      .cmd            (cmd),
      .stat           (stat),
      .status         (rsp_tuser),
      .chosen_path    (chosen_path)
   );

   assign rsp_tdata = RSP_TDATA_W'(chosen_path);

endmodule

### design/swps_ctrl.sv
// ----------------------------------------------------------------------------
// Smooth weighted path select: controller
// Handshake, output valid flag and the two passes over a list for a select.
// ----------------------------------------------------------------------------
module swps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  swps_pkg::swps_stat_type stat,
   output swps_pkg::swps_cmd_type  cmd
);
   import swps_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SUM  = 4'b0010,
      S_UPD  = 4'b0100,
      S_WB   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [PIDX_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              last;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tready && req_tvalid;
   assign last       = (CNT_W'(idx_ff) + CNT_W'(1)) == stat.count;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      cmd.accept  = accept;
      cmd.rd_en   = 1'b0;
      cmd.rd_upd  = 1'b0;
      cmd.rd_idx  = idx_ff;
      cmd.rsp_sel = 1'b0;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept && stat.sel_start) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            cmd.rd_en = 1'b1;
            if (last) begin
               state_in = S_UPD;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + PIDX_W'(1);
            end
         end
         S_UPD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_upd = 1'b1;
            if (last) begin
               state_in = S_WB;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + PIDX_W'(1);
            end
         end
         S_WB: begin
            cmd.rsp_sel = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if ((accept && !stat.sel_start) || cmd.rsp_sel) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_sel_enters_sum: assert property (@(posedge clock) disable iff (reset)
      (accept && stat.sel_start) |=> (state_ff == S_SUM))
      else $error("select did not start the sum pass");

   a_out_empty_in_pass: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SUM) || (state_ff == S_UPD)) |-> !rsp_valid_ff)
      else $error("result word pending while a select is at work");

   a_wb_gives_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("select finished without a result word");

   a_idx_in_list: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SUM) || (state_ff == S_UPD)) |-> (CNT_W'(idx_ff) < stat.count))
      else $error("entry index beyond the list");

endmodule

### design/swps_datapath.sv
// ----------------------------------------------------------------------------
// Smooth weighted path select: datapath
// List tables, entry memories, sum and maximum pass, credit update and the
// result register.
// ----------------------------------------------------------------------------
module swps_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [swps_pkg::ACTION_W-1:0]        action,
   input  logic [swps_pkg::GROUP_W-1:0]         group,
   input  logic                                 entry_first,
   input  logic [swps_pkg::PATH_W-1:0]          path_id,
   input  logic [swps_pkg::WEIGHT_W-1:0]        weight,
   input  logic signed [swps_pkg::CREDIT_W-1:0] initial_credit,
   input  swps_pkg::swps_cmd_type               cmd,
   output swps_pkg::swps_stat_type              stat,
   output logic [swps_pkg::STATUS_W-1:0]        status,
   output logic [swps_pkg::PATH_W-1:0]          chosen_path
);
   import swps_pkg::*;

   logic             group_valid_ff [NUM_GROUPS];
   logic [CNT_W-1:0] group_count_ff [NUM_GROUPS];

   logic [PATH_W-1:0]   path_mem   [MEM_DEPTH];
   logic [WEIGHT_W-1:0] weight_mem [MEM_DEPTH];
   logic [CREDIT_W-1:0] credit_mem [MEM_DEPTH];

   logic [GIDX_W-1:0]          gidx;
   logic [GIDX_W-1:0]          group_ff;
   logic                       in_range;
   logic                       cur_valid;
   logic [CNT_W-1:0]           cur_count;
   logic [CNT_W-1:0]           eff_count;
   logic                       full;
   logic                       do_load;
   logic                       do_delete;
   logic [STATUS_W-1:0]        imm_status;

   logic [PATH_W-1:0]          rd_path_ff;
   logic [WEIGHT_W-1:0]        rd_weight_ff;
   logic signed [CREDIT_W-1:0] rd_credit_ff;
   logic                       rd_en_ff;
   logic                       rd_upd_ff;
   logic [PIDX_W-1:0]          rd_idx_ff;

   logic [SUM_W-1:0]           sum_ff;
   logic signed [CREDIT_W-1:0] best_ff;
   logic [PIDX_W-1:0]          pick_ff;
   logic [PATH_W-1:0]          best_path_ff;

   logic signed [UPD_W-1:0]    upd_value;
   logic [CREDIT_W-1:0]        upd_credit;
   logic                       upd_wr;
   logic [ADDR_W-1:0]          ld_addr;
   logic [ADDR_W-1:0]          rd_addr;
   logic [ADDR_W-1:0]          wb_addr;

   logic [STATUS_W-1:0]        status_ff;
   logic [PATH_W-1:0]          chosen_ff;

   assign gidx      = GIDX_W'(group);
   assign in_range  = 32'(group) < NUM_GROUPS;
   assign cur_valid = group_valid_ff[gidx];
   assign cur_count = group_count_ff[gidx];
   assign eff_count = (entry_first || !cur_valid) ? '0 : cur_count;
   assign full      = eff_count >= CNT_W'(MAX_PATHS);
   assign do_load   = cmd.accept && (action == ACT_LOAD) && in_range;
   assign do_delete = cmd.accept && (action == ACT_DELETE) && in_range;

   assign stat.sel_start = (action == ACT_SELECT) && in_range && cur_valid &&
                           (cur_count != '0);
   assign stat.count     = group_count_ff[group_ff];

   always_comb begin
      imm_status = ST_OK;
      case (action)
         ACT_LOAD: begin
            if (!in_range) begin
               imm_status = ST_NOT_FOUND;
            end else if (full) begin
               imm_status = ST_FULL;
            end
         end
         ACT_SELECT: begin
            imm_status = ST_NOT_FOUND;
         end
         default: begin
            imm_status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_valid_ff[g] <= 1'b0;
            group_count_ff[g] <= '0;
         end
      end else if (do_load) begin
         group_valid_ff[gidx] <= 1'b1;
         group_count_ff[gidx] <= full ? eff_count : eff_count + CNT_W'(1);
      end else if (do_delete) begin
         group_valid_ff[gidx] <= 1'b0;
         group_count_ff[gidx] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         group_ff <= gidx;
      end
   end

   assign ld_addr = swps_addr(gidx, PIDX_W'(eff_count));
   assign rd_addr = swps_addr(group_ff, cmd.rd_idx);
   assign wb_addr = swps_addr(group_ff, rd_idx_ff);
   assign upd_wr  = rd_en_ff && rd_upd_ff;

   always_ff @(posedge clock) begin
      if (do_load && !full) begin
         path_mem[ld_addr]   <= path_id;
         weight_mem[ld_addr] <= weight;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_wr) begin
         credit_mem[wb_addr] <= upd_credit;
      end else if (do_load && !full) begin
         credit_mem[ld_addr] <= initial_credit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_path_ff   <= path_mem[rd_addr];
         rd_weight_ff <= weight_mem[rd_addr];
         rd_credit_ff <= credit_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_en_ff <= 1'b0;
      end else begin
         rd_en_ff <= cmd.rd_en;
      end
      rd_upd_ff <= cmd.rd_upd;
      rd_idx_ff <= cmd.rd_idx;
   end

   always_ff @(posedge clock) begin
      if (rd_en_ff && !rd_upd_ff) begin
         if (rd_idx_ff == '0) begin
            sum_ff       <= SUM_W'(rd_weight_ff);
            best_ff      <= rd_credit_ff;
            pick_ff      <= '0;
            best_path_ff <= rd_path_ff;
         end else begin
            sum_ff <= sum_ff + SUM_W'(rd_weight_ff);
            if (rd_credit_ff > best_ff) begin
               best_ff      <= rd_credit_ff;
               pick_ff      <= rd_idx_ff;
               best_path_ff <= rd_path_ff;
            end
         end
      end
   end

   always_comb begin
      upd_value = $signed({{(UPD_W - CREDIT_W){rd_credit_ff[CREDIT_W-1]}}, rd_credit_ff}) +
                  $signed({{(UPD_W - WEIGHT_W){1'b0}}, rd_weight_ff});
      if (rd_idx_ff == pick_ff) begin
         upd_value = upd_value - $signed({{(UPD_W - SUM_W){1'b0}}, sum_ff});
      end
      if ((&upd_value[UPD_W-1:CREDIT_W-1]) || !(|upd_value[UPD_W-1:CREDIT_W-1])) begin
         upd_credit = upd_value[CREDIT_W-1:0];
      end else if (upd_value[UPD_W-1]) begin
         upd_credit = {1'b1, {(CREDIT_W - 1){1'b0}}};
      end else begin
         upd_credit = {1'b0, {(CREDIT_W - 1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_sel) begin
         status_ff <= ST_OK;
         chosen_ff <= best_path_ff;
      end else if (cmd.accept && !stat.sel_start) begin
         status_ff <= imm_status;
         chosen_ff <= '0;
      end
   end

   assign status      = status_ff;
   assign chosen_path = chosen_ff;

endmodule
